// ===== sv/rlim_pkg.sv =====
// Shared types and constants for the per-source fixed-window rate limiter.
`timescale 1ns / 1ps

package rlim_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 48;
  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = 10;
  localparam int WINDOW_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 10'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              found;
    logic              allowed;
    logic              cleared;
  } tok_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  limit;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

endpackage

// ===== sv/rlim_cell.sv =====
// One bucket of the table; checks the passing request and hands it to the next cell.
`timescale 1ns / 1ps

module rlim_cell
  import rlim_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic clear,
  input  logic tok_in_valid,
  input  tok_t tok_in,
  output logic tok_out_valid,
  output tok_t tok_out,
  output logic occupied
);

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] win_start;
  logic [COUNT_W-1:0] count;

  logic              eff_valid;
  logic              take;
  logic [TIME_W-1:0] base_start;
  logic [COUNT_W-1:0] base_count;
  logic [TIME_W-1:0] diff;
  logic              restart;
  logic [TIME_W-1:0] start_next;
  logic [COUNT_W-1:0] count_mid;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] limit_ext;
  logic              allow_c;
  tok_t              tok_next;

  assign occupied = valid;

  always_comb begin
    eff_valid  = valid & ~clear;
    take       = tok_in_valid & ~tok_in.found & (~eff_valid | (key == tok_in.key));
    base_start = eff_valid ? win_start : '0;
    base_count = eff_valid ? count : '0;
    diff       = tok_in.now - base_start;
    restart    = (tok_in.now >= base_start) &&
                 (diff >= {{(TIME_W-WINDOW_W){1'b0}}, cfg.window});
    start_next = restart ? tok_in.now : base_start;
    count_mid  = restart ? '0 : base_count;
    limit_ext  = {{(COUNT_W-LIMIT_W){1'b0}}, cfg.limit};
    count_next = (count_mid <= limit_ext) ? count_mid + 1'b1 : count_mid;
    allow_c    = count_next <= limit_ext;
    tok_next   = tok_in;
    if (take) begin
      tok_next.found   = 1'b1;
      tok_next.allowed = allow_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
      if (take) begin
        valid <= 1'b1;
      end else if (clear) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (take) begin
      key       <= tok_in.key;
      win_start <= start_next;
      count     <= count_next;
    end
  end

endmodule

// ===== sv/per_source_fixed_window_rate_limiter.sv =====
// Top level: config registers, request entry and the chain of bucket cells.
//
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+----------------------------
//  request  | start, busy, source_addr, now_ms         | start & !busy
//  result   | done, allowed, table_was_cleared         | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
// A request walks the chain of TABLE_CAPACITY+1 cells, one cell per cycle; the
// result shows as the request leaves the last cell, and a new request can follow
// in the cycle after the result.
// Reset empties the table and loads the config defaults; no clearing pass is needed.
// A full table is emptied in the cycle the next request is taken.
// Hold config writes off while start is high or a request is in flight.
`timescale 1ns / 1ps

module per_source_fixed_window_rate_limiter
  import rlim_pkg::*;
#(
  parameter int TABLE_CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_W-1:0]      source_addr,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  done,
  output logic                  allowed,
  output logic                  table_was_cleared,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = TABLE_CAPACITY + 1;

  logic [LIMIT_W-1:0]  limit_per_window;
  logic [WINDOW_W-1:0] window_length_ms;
  cfg_t                cfg;

  logic       accept;
  logic       clear;
  tok_t       tok   [0:DEPTH];
  logic       tok_v [0:DEPTH];
  logic [DEPTH-1:0] occ;

  assign cfg_ready = ~busy & ~start;
  assign cfg.limit  = limit_per_window;
  assign cfg.window = window_length_ms;

  assign accept = start & ~busy;
  assign clear  = accept & occ[DEPTH-1];

  assign tok[0]   = {source_addr, now_ms, 1'b0, 1'b0, clear};
  assign tok_v[0] = accept;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rlim_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cfg          (cfg),
      .clear        (clear),
      .tok_in_valid (tok_v[i]),
      .tok_in       (tok[i]),
      .tok_out_valid(tok_v[i+1]),
      .tok_out      (tok[i+1]),
      .occupied     (occ[i])
    );
  end

  assign done              = tok_v[DEPTH];
  assign allowed           = tok[DEPTH].allowed;
  assign table_was_cleared = tok[DEPTH].cleared;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_per_window <= LIMIT_RESET;
      window_length_ms <= WINDOW_RESET;
      busy             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIMIT:  limit_per_window <= cfg_data[LIMIT_W-1:0];
          REG_WINDOW: window_length_ms <= cfg_data;
          default:    ;
        endcase
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/rlim_checker.sv =====
// Port-level checks for the rate limiter and their bind to the top level.
`timescale 1ns / 1ps

module rlim_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  a_done_in_flight: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result without a request in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result in the cycle after request transfer");

endmodule

bind per_source_fixed_window_rate_limiter rlim_checker u_rlim_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// ===== tb/tb.sv =====
// Testbench for the per-source rate limiter: bucket-table predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb;
  import rlim_pkg::*;

  localparam int TABLE_CAPACITY = 256;
  localparam int TABLE_DEPTH    = TABLE_CAPACITY + 1;
  localparam int REQUEST_TARGET = 1850;
  localparam int CYCLE_LIMIT    = 5000000;

  typedef struct packed {
    logic allowed;
    logic cleared;
  } verdict_t;

  class bucket_ledger;
    logic [LIMIT_W-1:0]  limit;
    logic [WINDOW_W-1:0] window;
    bit                  live   [TABLE_DEPTH];
    logic [KEY_W-1:0]    owner  [TABLE_DEPTH];
    logic [TIME_W-1:0]   opened [TABLE_DEPTH];
    logic [COUNT_W-1:0]  tally  [TABLE_DEPTH];
    int unsigned         entries;
    verdict_t            verdict_q[$];
    int unsigned         failures;
    int unsigned         results;
    int unsigned         rejects;
    int unsigned         clears;

    function new();
      limit    = LIMIT_RESET;
      window   = WINDOW_RESET;
      entries  = 0;
      failures = 0;
      results  = 0;
      rejects  = 0;
      clears   = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LIMIT: begin
          limit = data[LIMIT_W-1:0];
        end
        REG_WINDOW: begin
          window = data[WINDOW_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void take_request(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
      verdict_t v;
      int       slot;
      v.cleared = 1'b0;
      if (entries > TABLE_CAPACITY) begin
        foreach (live[i]) live[i] = 1'b0;
        entries   = 0;
        v.cleared = 1'b1;
      end
      slot = -1;
      foreach (live[i]) begin
        if (slot < 0 && live[i] && owner[i] == key) slot = i;
      end
      if (slot < 0) begin
        slot         = (entries > TABLE_CAPACITY) ? TABLE_CAPACITY : entries;
        live[slot]   = 1'b1;
        owner[slot]  = key;
        opened[slot] = '0;
        tally[slot]  = '0;
        entries++;
      end
      if (now >= opened[slot] && (now - opened[slot]) >= TIME_W'(window)) begin
        opened[slot] = now;
        tally[slot]  = '0;
      end
      if (tally[slot] <= COUNT_W'(limit)) tally[slot] = tally[slot] + 1'b1;
      v.allowed = (tally[slot] <= COUNT_W'(limit));
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(logic ok, logic cleared);
      verdict_t want;
      results++;
      if (ok === 1'b0) rejects++;
      if (cleared === 1'b1) clears++;
      if (verdict_q.size() == 0) begin
        failures++;
        $display("%0t: result with no request pending, expected none, actual allowed=%0b cleared=%0b",
                 $time, ok, cleared);
        return;
      end
      want = verdict_q.pop_front();
      if (ok !== want.allowed) begin
        failures++;
        $display("%0t: allowed mismatch, expected %0b actual %0b", $time, want.allowed, ok);
      end
      if (cleared !== want.cleared) begin
        failures++;
        $display("%0t: table_was_cleared mismatch, expected %0b actual %0b",
                 $time, want.cleared, cleared);
      end
    endfunction
  endclass

  logic                  clk               = 1'b0;
  logic                  rst               = 1'b1;
  logic                  start             = 1'b0;
  logic [KEY_W-1:0]      source_addr       = '0;
  logic [TIME_W-1:0]     now_ms            = '0;
  logic                  cfg_valid         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;
  logic                  busy;
  logic                  done;
  logic                  allowed;
  logic                  table_was_cleared;
  logic                  cfg_ready;

  bucket_ledger      ledger = new();
  int unsigned       cycle_count = 0;
  int unsigned       issued = 0;
  int unsigned       reg_writes = 0;
  int unsigned       window_now = 1000;
  int unsigned       burst_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [KEY_W-1:0]  pool [12];

  per_source_fixed_window_rate_limiter #(
    .TABLE_CAPACITY(TABLE_CAPACITY)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .source_addr      (source_addr),
    .now_ms           (now_ms),
    .done             (done),
    .allowed          (allowed),
    .table_was_cleared(table_was_cleared),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) ledger.check_verdict(allowed, table_was_cleared);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] t);
    start       <= 1'b1;
    source_addr <= key;
    now_ms      <= t;
    do @(posedge clk); while (busy);
    ledger.take_request(key, t);
    issued++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (ledger.verdict_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_register(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic start_phase(output int unsigned pool_n);
    int unsigned      pick;
    logic [LIMIT_W-1:0] lim;
    pick = $urandom_range(0, 9);
    if (pick < 2)      lim = LIMIT_W'($urandom_range(1, 3));
    else if (pick < 7) lim = LIMIT_W'($urandom_range(1, 12));
    else if (pick < 8) lim = '0;
    else if (pick < 9) lim = '1;
    else               lim = LIMIT_W'($urandom_range(1, 1023));
    pick = $urandom_range(0, 9);
    if (pick < 4)      window_now = $urandom_range(1, 20);
    else if (pick < 7) window_now = $urandom_range(20, 300);
    else if (pick < 8) window_now = 0;
    else if (pick < 9) window_now = 65535;
    else               window_now = $urandom_range(1, 65535);
    if ($urandom_range(0, 1) == 0) begin
      program_register(REG_LIMIT, {6'($urandom), lim});
      program_register(REG_WINDOW, CFG_DATA_W'(window_now));
    end else begin
      program_register(REG_WINDOW, CFG_DATA_W'(window_now));
      program_register(REG_LIMIT, {6'($urandom), lim});
    end
    pool_n = $urandom_range(2, 12);
    for (int i = 0; i < 12; i++) pool[i] = {$urandom, $urandom};
    if ($urandom_range(0, 6) == 0) clock_ms = {16'($urandom), $urandom};
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 400));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic mixed_request(input int unsigned pool_n);
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) clock_ms += $urandom_range(0, 2 * window_now + 2);
    else                           clock_ms += $urandom_range(0, window_now / 4 + 1);
    t = clock_ms;
    if (pick < 65) begin
      key = pool[$urandom_range(0, pool_n - 1)];
    end else if (pick < 85) begin
      key = {$urandom, $urandom};
    end else if (pick < 92) begin
      key = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else begin
      key = pool[$urandom_range(0, pool_n - 1)];
      t   = clock_ms - $urandom_range(1, window_now + 1);
    end
    send_request(key, t);
  endtask

  initial begin
    int unsigned pool_n;
    int unsigned phase_len;
    bit          flood;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request('0, '0);
    send_request('1, '1);
    send_request('0, 48'd999);
    send_request('0, 48'd1000);

    program_register(REG_LIMIT, 16'hFC02);
    program_register(REG_WINDOW, 16'hFFFF);
    repeat (4) send_request(64'h0123_4567_89AB_CDEF, 48'd10);
    send_request(64'h0123_4567_89AB_CDEF, 48'd65545);
    send_request(64'h0123_4567_89AB_CDEF, 48'd5);
    send_request(64'h0123_4567_89AB_CDEF, 48'd5);

    program_register(2'd2, 16'hFFFF);
    program_register(2'd3, 16'h0000);
    program_register(REG_LIMIT, 16'h0000);
    send_request(64'hFEDC_BA98_7654_3210, 48'd100);
    send_request(64'hFEDC_BA98_7654_3210, 48'd100);

    program_register(REG_LIMIT, 16'h03FF);
    program_register(REG_WINDOW, 16'h0000);
    send_request(64'h8000_0000_0000_0001, 48'd7);
    send_request(64'h8000_0000_0000_0001, 48'd7);
    send_request(64'h8000_0000_0000_0001, 48'd3);

    clock_ms = 48'd200000;
    while (issued < REQUEST_TARGET) begin
      start_phase(pool_n);
      flood     = ($urandom_range(0, 4) == 0);
      phase_len = flood ? $urandom_range(240, 300) : $urandom_range(40, 120);
      for (int n = 0; n < phase_len && issued < REQUEST_TARGET; n++) begin
        pace_sender();
        if (flood) begin
          clock_ms += $urandom_range(0, 2);
          send_request({$urandom, $urandom}, clock_ms);
        end else begin
          mixed_request(pool_n);
          if ($urandom_range(0, 39) == 0) wait_for_results();
        end
      end
    end

    wait_for_results();
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    $display("covered %0d requests and %0d register writes over changing limits and windows",
             issued, reg_writes);
    $display("saw %0d results, %0d rejected, %0d table flushes",
             ledger.results, ledger.rejects, ledger.clears);
    if (ledger.failures == 0 && ledger.verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rlim_pkg.sv
sv/rlim_cell.sv
sv/per_source_fixed_window_rate_limiter.sv
sv/rlim_checker.sv
tb/tb.sv
